FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define STPM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define STPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/stpm_pkg.sv
`default_nettype none

package stpm_pkg;

	localparam int PEN_W      = 16;
	localparam int TPRIO_W    = 3;
	localparam int PIX_W      = 16;
	localparam int ADDR_W     = 12;
	localparam int DATA_W     = 8;
	localparam int SPEN_W     = 12;
	localparam int SPRIO_W    = 4;
	localparam int MASK_W     = 8;
	localparam int ENTRIES    = 1 << SPRIO_W;
	localparam int PROBE_W    = 3;

	localparam logic OP_MIX   = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [MASK_W-1:0] MASK_OPEN   = 8'h00;
	localparam logic [MASK_W-1:0] MASK_TEXT   = 8'hf0;
	localparam logic [MASK_W-1:0] MASK_ROZ    = 8'hfc;
	localparam logic [MASK_W-1:0] MASK_SHADOW = 8'hfe;
	localparam logic [MASK_W-1:0] MASK_NOISE  = 8'hc0;

	localparam logic [15:0] NOISE_TAPS = 16'hb400;
	localparam logic [15:0] NOISE_SEED = 16'h0001;

	// the eight probe addresses are {~k2,1,~k1,1,~k0, sprite priority, 3'b000}
	function automatic logic probe_hit(input logic [ADDR_W-1:0] addr);
		probe_hit = addr[10] & addr[8] & (addr[2:0] == 3'b000);
	endfunction

	function automatic logic [PROBE_W-1:0] probe_bit(input logic [ADDR_W-1:0] addr);
		probe_bit = ~{addr[11], addr[9], addr[7]};
	endfunction

	function automatic logic [15:0] noise_next(input logic [15:0] cur);
		logic [15:0] nxt;
		nxt = cur >> 1;
		if (cur[0]) begin
			nxt = nxt ^ NOISE_TAPS;
		end
		noise_next = nxt;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stpm_if.sv
`default_nettype none

interface stpm_in_if import stpm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [PEN_W-1:0]   tile_pen;
	logic [TPRIO_W-1:0] tile_priority;
	logic [PIX_W-1:0]   sprite_pixel;
	logic [ADDR_W-1:0]  prio_addr;
	logic [DATA_W-1:0]  prio_data;

	modport source (output valid, operation, tile_pen, tile_priority, sprite_pixel,
		prio_addr, prio_data, input ready);
	modport sink (input valid, operation, tile_pen, tile_priority, sprite_pixel,
		prio_addr, prio_data, output ready);
endinterface

interface stpm_out_if import stpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PEN_W-1:0] pen;
	logic             shadow;
	logic             unhandled;

	modport source (output valid, pen, shadow, unhandled, input ready);
	modport sink (input valid, pen, shadow, unhandled, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sprite_tile_priority_mixer_unit.sv
`default_nettype none
`include "assert_macros.svh"

// channel   dir  carries
// pix_in    in   mix item (pens, priorities) or priority ram byte write
// pix_out   out  pen, shadow, unhandled; one per mix item, none per write
//
// one item per cycle unless a result stalls; the result register loads as stage 1 moves on
// the 16-entry mask memory is read at transfer and written back as stage 1 moves on;
// a write back is forwarded to the item right behind it
// reset clears the mask valid bits and seeds the noise lfsr, no clearing pass
// a stalled result holds stage 1 and input ready drops only behind it

module sprite_tile_priority_mixer_unit import stpm_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	stpm_in_if.sink    pix_in,
	stpm_out_if.source pix_out
);

	// only the 128 bytes that are ever probed matter: kept as one mask byte per sprite priority
	logic [MASK_W-1:0]  mask_mem [ENTRIES];
	logic [ENTRIES-1:0] mask_vld_q;

	logic                s1_valid_q;
	logic                op_s1;
	logic [SPRIO_W-1:0]  idx_s1;
	logic [PEN_W-1:0]    tile_pen_s1;
	logic [TPRIO_W-1:0]  tile_prio_s1;
	logic [SPEN_W-1:0]   spen_s1;
	logic                wr_hit_s1;
	logic [PROBE_W-1:0]  wr_bit_s1;
	logic                wr_val_s1;
	logic [MASK_W-1:0]   rd_data_s1;
	logic                rd_vld_s1;

	logic                fwd_vld_q;
	logic [SPRIO_W-1:0]  fwd_idx_q;
	logic [MASK_W-1:0]   fwd_data_q;

	logic [15:0]         lfsr_q;

	logic                out_valid_q;
	logic [PEN_W-1:0]    out_pen_q;
	logic                out_shadow_q;
	logic                out_unh_q;

	logic                in_xfer;
	logic                s1_go;
	logic [SPRIO_W-1:0]  rd_idx;
	logic [MASK_W-1:0]   cur_mask;
	logic [MASK_W-1:0]   new_mask;
	logic                wr_en;
	logic [15:0]         lfsr_nxt;
	logic [PEN_W-1:0]    mix_pen;
	logic                mix_shadow;
	logic                mix_unh;
	logic                sprite_win;
	logic [PEN_W-1:0]    spen_ext;
	logic [PEN_W-1:0]    sprite_or_tile;

	assign s1_go   = s1_valid_q && (op_s1 == OP_WRITE || !out_valid_q || pix_out.ready);
	assign pix_in.ready = !s1_valid_q || s1_go;
	assign in_xfer = pix_in.valid && pix_in.ready;
	assign rd_idx  = (pix_in.operation == OP_WRITE) ? pix_in.prio_addr[6:3]
		: pix_in.sprite_pixel[PIX_W-1 -: SPRIO_W];

	// memory read port, registered
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_data_s1 <= mask_mem[rd_idx];
		end
		if (wr_en) begin
			mask_mem[idx_s1] <= new_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1        <= pix_in.operation;
			idx_s1       <= rd_idx;
			tile_pen_s1  <= pix_in.tile_pen;
			tile_prio_s1 <= pix_in.tile_priority;
			spen_s1      <= pix_in.sprite_pixel[SPEN_W-1:0];
			wr_hit_s1    <= probe_hit(pix_in.prio_addr);
			wr_bit_s1    <= probe_bit(pix_in.prio_addr);
			wr_val_s1    <= |pix_in.prio_data[5:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			rd_vld_s1 <= mask_vld_q[rd_idx];
		end
	end

	// take the write back of the previous stage-1 transfer, it missed the read
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == idx_s1) begin
			cur_mask = fwd_data_q;
		end else if (rd_vld_s1) begin
			cur_mask = rd_data_s1;
		end else begin
			cur_mask = '0;
		end
		new_mask = cur_mask;
		new_mask[wr_bit_s1] = wr_val_s1;
	end

	assign wr_en = s1_go && op_s1 == OP_WRITE && wr_hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			mask_vld_q <= '0;
			fwd_vld_q  <= 1'b0;
			lfsr_q     <= NOISE_SEED;
		end else begin
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				mask_vld_q[idx_s1] <= 1'b1;
			end
			if (s1_go) begin
				fwd_vld_q <= wr_en;
			end
			if (s1_go && op_s1 == OP_MIX) begin
				lfsr_q <= lfsr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= new_mask;
		end
	end

	// pixel selection
	assign lfsr_nxt       = noise_next(lfsr_q);
	assign spen_ext       = {{(PEN_W-SPEN_W){1'b0}}, spen_s1};
	assign sprite_win     = |spen_s1[7:0];
	assign sprite_or_tile = sprite_win ? spen_ext : tile_pen_s1;

	always_comb begin
		mix_pen    = '0;
		mix_shadow = 1'b0;
		mix_unh    = 1'b0;
		case (cur_mask)
			MASK_OPEN: begin
				mix_pen = sprite_or_tile;
			end
			MASK_TEXT: begin
				mix_pen = !tile_prio_s1[2] ? sprite_or_tile : tile_pen_s1;
			end
			MASK_ROZ: begin
				mix_pen = (tile_prio_s1[2:1] == 2'b00) ? sprite_or_tile : tile_pen_s1;
			end
			MASK_SHADOW: begin
				if (tile_prio_s1 == '0) begin
					mix_pen = sprite_or_tile;
				end else begin
					mix_pen    = tile_pen_s1;
					mix_shadow = !tile_prio_s1[2];
				end
			end
			MASK_NOISE: begin
				mix_pen = {{(PEN_W-SPEN_W){1'b0}}, lfsr_nxt[SPEN_W-1:0]};
			end
			default: begin
				mix_unh = 1'b1;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && op_s1 == OP_MIX) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1 == OP_MIX) begin
			out_pen_q    <= mix_pen;
			out_shadow_q <= mix_shadow;
			out_unh_q    <= mix_unh;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.pen       = out_pen_q;
	assign pix_out.shadow    = out_shadow_q;
	assign pix_out.unhandled = out_unh_q;

	`STPM_ASSERT_SAME(a_lfsr_alive, clk, arst_n, 1'b1, lfsr_q != '0)
	`STPM_ASSERT_SAME(a_ready_only_on_stall, clk, arst_n, !pix_in.ready,
		s1_valid_q && out_valid_q && !pix_out.ready && op_s1 == OP_MIX)
	`STPM_ASSERT_NEXT(a_mix_gives_result, clk, arst_n, s1_go && op_s1 == OP_MIX,
		out_valid_q)
	`STPM_ASSERT_SAME(a_unhandled_blank, clk, arst_n, out_valid_q && out_unh_q,
		out_pen_q == '0 && !out_shadow_q)

endmodule

`default_nettype wire

FILE: tb/stpm_mix_checker.sv
`timescale 1ns / 100ps

module stpm_mix_checker import stpm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	stpm_in_if          pix_in,
	stpm_out_if         pix_out,
	output int unsigned failures,
	output int unsigned pending
);

	typedef struct packed {
		logic [PEN_W-1:0] pen;
		logic             shadow;
		logic             unhandled;
	} pixel_result_t;

	// probe offsets for mask bits 0..7, before the halving into a byte address
	localparam logic [7:0][12:0] PROBE_OFF = {13'h0000, 13'h0100, 13'h0400, 13'h0500,
		13'h1000, 13'h1100, 13'h1400, 13'h1500};
	localparam int RAM_DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] prio_bytes [RAM_DEPTH];
	logic [15:0]       noise_state;
	pixel_result_t     expected_pixels [$];
	pixel_result_t     want;
	int                idx;

	function automatic pixel_result_t mix_pixel(input logic [PEN_W-1:0] tpen,
		input logic [TPRIO_W-1:0] tprio, input logic [PIX_W-1:0] spix);
		pixel_result_t     r;
		logic [MASK_W-1:0] mask;
		logic [12:0]       probe;
		logic [PEN_W-1:0]  sprite_or_tile;
		int                k;
		mask = '0;
		for (k = 0; k < MASK_W; k++) begin
			probe = {5'b0, spix[15:12], 4'b0} | 13'h0a00 | PROBE_OFF[k];
			mask[k] = (prio_bytes[probe[12:1]] & 8'h38) != 8'h00;
		end
		// a sprite pen only wins when its low byte is nonzero
		sprite_or_tile = (spix[7:0] != 8'h00) ? {4'b0, spix[11:0]} : tpen;
		r = '0;
		case (mask)
			MASK_OPEN: begin
				r.pen = sprite_or_tile;
			end
			MASK_TEXT: begin
				r.pen = (tprio <= 3'd3) ? sprite_or_tile : tpen;
			end
			MASK_ROZ: begin
				r.pen = (tprio <= 3'd1) ? sprite_or_tile : tpen;
			end
			MASK_SHADOW: begin
				if (tprio == 3'd0) begin
					r.pen = sprite_or_tile;
				end else begin
					r.pen = tpen;
					r.shadow = (tprio <= 3'd3);
				end
			end
			MASK_NOISE: begin
				r.pen = {4'b0, noise_state[11:0]};
			end
			default: begin
				r.unhandled = 1'b1;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (idx = 0; idx < RAM_DEPTH; idx++) begin
				prio_bytes[idx] = '0;
			end
			noise_state = NOISE_SEED;
			expected_pixels.delete();
			failures = 0;
			pending = 0;
		end else begin
			// results leave in a later cycle than their item, so check before predicting
			if (pix_out.valid && pix_out.ready) begin
				if (expected_pixels.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, expected none, got pen %h shadow %b unhandled %b",
						$time, pix_out.pen, pix_out.shadow, pix_out.unhandled);
				end else begin
					want = expected_pixels.pop_front();
					if (pix_out.pen !== want.pen) begin
						failures++;
						$display("%0t: pen expected %h got %h", $time, want.pen, pix_out.pen);
					end
					if (pix_out.shadow !== want.shadow) begin
						failures++;
						$display("%0t: shadow expected %b got %b", $time, want.shadow,
							pix_out.shadow);
					end
					if (pix_out.unhandled !== want.unhandled) begin
						failures++;
						$display("%0t: unhandled expected %b got %b", $time, want.unhandled,
							pix_out.unhandled);
					end
				end
			end
			if (pix_in.valid && pix_in.ready) begin
				if (pix_in.operation == OP_WRITE) begin
					prio_bytes[pix_in.prio_addr] = pix_in.prio_data;
				end else begin
					// noise steps on every mix, before its pen is taken
					noise_state = {1'b0, noise_state[15:1]} ^ (noise_state[0] ? NOISE_TAPS : 16'h0000);
					expected_pixels.push_back(mix_pixel(pix_in.tile_pen, pix_in.tile_priority,
						pix_in.sprite_pixel));
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb import stpm_pkg::*; ();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned failures;
	int unsigned pending;
	int unsigned offered = 0;
	int unsigned send_quiet = 0;

	stpm_in_if  pix_in ();
	stpm_out_if pix_out ();

	sprite_tile_priority_mixer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	stpm_mix_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.pix_out  (pix_out),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("sprite_tile_priority_mixer_unit regression: fail");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic offer(input logic op, input logic [PEN_W-1:0] tpen,
		input logic [TPRIO_W-1:0] tprio, input logic [PIX_W-1:0] spix,
		input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		int unsigned gap;
		gap = (send_quiet != 0) ? 0 : $urandom_range(0, 13);
		if (send_quiet != 0) begin
			send_quiet--;
		end
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.operation     <= op;
		pix_in.tile_pen      <= tpen;
		pix_in.tile_priority <= tprio;
		pix_in.sprite_pixel  <= spix;
		pix_in.prio_addr     <= addr;
		pix_in.prio_data     <= data;
		pix_in.valid         <= 1'b1;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
		offered++;
	endtask

	// fill the eight probe bytes of one sprite priority; partial skips some at random
	task automatic program_mask(input logic [SPRIO_W-1:0] sprio, input logic [MASK_W-1:0] mask,
		input bit partial);
		logic [DATA_W-1:0] data;
		logic [2:0]        k;
		int                i;
		for (i = 0; i < MASK_W; i++) begin
			k = i[2:0];
			data = DATA_W'($urandom);
			data[5:3] = mask[i] ? 3'($urandom_range(1, 7)) : 3'b000;
			if (!partial || $urandom_range(0, 1) == 1) begin
				offer(OP_WRITE, PEN_W'($urandom), TPRIO_W'($urandom), PIX_W'($urandom),
					{~k[2], 1'b1, ~k[1], 1'b1, ~k[0], sprio, 3'b000}, data);
			end
		end
	endtask

	task automatic mix_burst(input logic [SPRIO_W-1:0] sprio, input int unsigned count);
		logic [PIX_W-1:0] spix;
		repeat (count) begin
			spix = PIX_W'($urandom);
			if ($urandom_range(0, 4) != 0) begin
				spix[15:12] = sprio;
			end
			if ($urandom_range(0, 3) == 0) begin
				spix[7:0] = '0;
			end
			offer(OP_MIX, PEN_W'($urandom), TPRIO_W'($urandom), spix, ADDR_W'($urandom),
				DATA_W'($urandom));
		end
	endtask

	initial begin : pen_sink
		int unsigned gap;
		int unsigned taken;
		int unsigned quiet_left;
		pix_out.ready = 1'b0;
		taken = 0;
		quiet_left = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 300) begin
				// long hold so the pipeline backs up into the input
				gap = 400;
			end else if (quiet_left != 0) begin
				gap = 0;
				quiet_left--;
			end else begin
				gap = $urandom_range(0, 13);
				if ($urandom_range(0, 19) == 0) begin
					quiet_left = $urandom_range(10, 40);
				end
			end
			@(negedge clk);
			if (gap != 0) begin
				pix_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
			taken++;
		end
	end

	initial begin : pixel_source
		logic [SPRIO_W-1:0] sprio;
		logic [MASK_W-1:0]  mask;
		int unsigned        kind;
		int                 tp;
		pix_in.valid         = 1'b0;
		pix_in.operation     = OP_MIX;
		pix_in.tile_pen      = '0;
		pix_in.tile_priority = '0;
		pix_in.sprite_pixel  = '0;
		pix_in.prio_addr     = '0;
		pix_in.prio_data     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// cleared store: every mask is open
		offer(OP_MIX, 16'h0000, 3'd7, 16'hffff, '0, '0);
		offer(OP_MIX, 16'hffff, 3'd0, 16'h0f00, '1, '1);
		offer(OP_MIX, 16'ha5a5, 3'd4, 16'h0000, '0, '0);
		offer(OP_WRITE, '1, '1, '1, 12'hfff, 8'hff);
		offer(OP_WRITE, '0, '0, '0, 12'h000, 8'h00);
		// shadow mask on the top sprite priority, swept over every tile priority
		program_mask(4'hf, MASK_SHADOW, 1'b0);
		for (tp = 0; tp < 8; tp++) begin
			offer(OP_MIX, 16'h5a5a, tp[2:0], 16'hf0ff, '0, '0);
		end

		while (offered < 1350) begin
			if ($urandom_range(0, 5) == 0) begin
				send_quiet = $urandom_range(8, 30);
			end
			sprio = SPRIO_W'($urandom);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				case ($urandom_range(0, 5))
					0: mask = MASK_OPEN;
					1: mask = MASK_TEXT;
					2: mask = MASK_ROZ;
					3: mask = MASK_SHADOW;
					4: mask = MASK_NOISE;
					default: mask = MASK_W'($urandom);
				endcase
				program_mask(sprio, mask, 1'b0);
				mix_burst(sprio, $urandom_range(6, 24));
			end else if (kind < 9) begin
				program_mask(sprio, MASK_W'($urandom), 1'b1);
				mix_burst(sprio, $urandom_range(2, 8));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					offer(OP_WRITE, PEN_W'($urandom), TPRIO_W'($urandom),
						PIX_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
				end
			end
		end
		pix_in.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (failures == 0) begin
			$display("sprite_tile_priority_mixer_unit regression: pass");
		end else begin
			$display("sprite_tile_priority_mixer_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/stpm_pkg.sv
hw/rtl/stpm_if.sv
hw/rtl/sprite_tile_priority_mixer_unit.sv
tb/stpm_mix_checker.sv
tb/tb.sv
